// ----- src/bpp_pkg.sv -----
// bitfield pixel premultiply: shared types and constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned SH_W      = 5;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_RED_MASK   = 2'd1,
    CFG_GREEN_MASK = 2'd2,
    CFG_BLUE_MASK  = 2'd3
  } cfg_idx_e;

  // register reset values
  localparam logic [PIX_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [PIX_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

  typedef struct packed {
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } argb_t;

  // handshake between queue and back end
  typedef struct packed {
    logic  valid;
    argb_t data;
  } word_t;

  // queue between front and back end
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  // arithmetic lane
  localparam int unsigned CSQ_W       = 2 * CH_W;
  localparam int unsigned X_W         = 3 * CH_W;
  localparam int unsigned Q_W         = 20;
  localparam int unsigned ROOT_W      = Q_W / 2;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned SQRT_STEPS  = Q_W / 2;
  localparam int unsigned LANE_LAT    = SQRT_STEPS + 4;
  localparam logic [31:0] RECIP_255   = 32'h8080_8081;
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned PROD_W      = X_W + 2 + 32;

endpackage

`default_nettype wire

// ----- src/bpp_front.sv -----
// front end: configuration registers, channel extraction, push into the queue
// depends on bpp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpp_front import bpp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PIX_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PIX_W-1:0]     source_pixel_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output argb_t                     push_data_o
);

  logic             mode_q;
  logic [PIX_W-1:0] red_mask_q, green_mask_q, blue_mask_q;
  logic [PIX_W-1:0] a_field_sel;

  // lowest set bit, zero for an empty mask
  function automatic logic [SH_W-1:0] low_bit_index(input logic [PIX_W-1:0] m);
    logic [SH_W-1:0] idx;
    idx = '0;
    for (int i = PIX_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SH_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [CH_W-1:0] take_channel(input logic [PIX_W-1:0] px,
                                                   input logic [PIX_W-1:0] m);
    logic [PIX_W-1:0] sh;
    sh = px >> low_bit_index(m);
    return sh[CH_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      red_mask_q   <= RED_MASK_RST;
      green_mask_q <= GREEN_MASK_RST;
      blue_mask_q  <= BLUE_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:       mode_q       <= cfg_wdata_i[0];
        CFG_RED_MASK:   red_mask_q   <= cfg_wdata_i;
        CFG_GREEN_MASK: green_mask_q <= cfg_wdata_i;
        CFG_BLUE_MASK:  blue_mask_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign a_field_sel = ~(red_mask_q | green_mask_q | blue_mask_q);

  always_comb begin
    if (mode_q) begin
      push_data_o.a = take_channel(source_pixel_i, a_field_sel);
      push_data_o.r = take_channel(source_pixel_i, red_mask_q);
      push_data_o.g = take_channel(source_pixel_i, green_mask_q);
      push_data_o.b = take_channel(source_pixel_i, blue_mask_q);
    end else begin
      push_data_o = argb_t'(source_pixel_i);
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

// ----- src/bpp_fifo.sv -----
// short queue that decouples the front end from the arithmetic back end
// depends on bpp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpp_fifo import bpp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire argb_t push_data_i,
  output logic       full_o,
  output word_t      head_o,
  input  wire logic  pop_i
);

  argb_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/bpp_lane.sv -----
// one colour lane: round(sqrt(c*c*a/255)) as a stallable pipeline
// depends on bpp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpp_lane import bpp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [CH_W-1:0] c_i,
  input  wire logic [CH_W-1:0] a_i,
  output logic      [CH_W-1:0] y_o
);

  logic [CSQ_W-1:0]  csq_q;
  logic [CH_W-1:0]   a1_q;
  logic [X_W-1:0]    x_q;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_q;
  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  logic [Q_W-1:0]    rad_q  [SQRT_STEPS];
  logic [CH_W-1:0]   y_q;

  // floor(4x/255) via reciprocal, exact for any 32-bit dividend
  assign prod = PROD_W'({x_q, 2'b00}) * PROD_W'(RECIP_255);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      csq_q <= CSQ_W'(c_i) * CSQ_W'(c_i);
      a1_q  <= a_i;
      x_q   <= X_W'(csq_q) * X_W'(a1_q);
      q_q   <= Q_W'(prod[PROD_W-1:RECIP_SHIFT]);
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [Q_W-1:0]    rad_in;
    logic [REM_W+1:0]  acc;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = q_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign acc   = {rem_in, rad_in[Q_W-1 -: 2]};
    assign trial = {{(REM_W - ROOT_W){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= rad_in << 2;
        if (acc >= trial) begin
          rem_q[k]  <= REM_W'(acc - trial);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= REM_W'(acc);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // sqrt(4x/255) floored is 2y-1 or 2y, so y = (s+1)/2 rounded down
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= CH_W'(((ROOT_W + 1)'(root_q[SQRT_STEPS-1]) + 1'b1) >> 1);
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

// ----- src/bpp_back.sv -----
// back end: three colour lanes, alpha delay line and output valid tracking
// depends on bpp_pkg, bpp_lane
`timescale 1ns / 1ps
`default_nettype none

module bpp_back import bpp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire word_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output argb_t      out_data_o
);

  logic            en;
  logic            vld_q   [LANE_LAT];
  logic [CH_W-1:0] alpha_q [LANE_LAT];
  logic [CH_W-1:0] r_y, g_y, b_y;

  // whole pipeline advances unless the last word is stuck
  assign en    = !vld_q[LANE_LAT-1] || out_ready_i;
  assign pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= head_i.valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q[0] <= head_i.data.a;
      for (int i = 1; i < LANE_LAT; i++) begin
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  bpp_lane u_lane_r (.clk_i, .en_i(en), .c_i(head_i.data.r), .a_i(head_i.data.a), .y_o(r_y));
  bpp_lane u_lane_g (.clk_i, .en_i(en), .c_i(head_i.data.g), .a_i(head_i.data.a), .y_o(g_y));
  bpp_lane u_lane_b (.clk_i, .en_i(en), .c_i(head_i.data.b), .a_i(head_i.data.a), .y_o(b_y));

  assign out_valid_o  = vld_q[LANE_LAT-1];
  assign out_data_o.a = alpha_q[LANE_LAT-1];
  assign out_data_o.r = r_y;
  assign out_data_o.g = g_y;
  assign out_data_o.b = b_y;

endmodule

`default_nettype wire

// ----- src/bitfield_pixel_premultiply_unit.sv -----
// top level of the bitfield pixel premultiply block
// depends on bpp_pkg, bpp_front, bpp_fifo, bpp_back
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// -------   ---------  ---------------------  ------------------------------------
// config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
// pixel     in         in_valid_i/in_ready_o  source_pixel_i
// result    out        out_valid_o/out_ready_i alpha_out_o, red_out_o, green_out_o,
//                                              blue_out_o
//
// one word per clock sustained while the result is not stalled; from pixel accept to result
// valid the word is registered in the 2-entry queue, then the pop edge loads the first of the
// 14 lane registers: two multiplies, the divide-by-255 reciprocal stage, ten square
// root bit stages and the output register, which drives the result
// a stalled result freezes the back end; the queue keeps taking pixels until full,
// and once the stall clears the input is held off until a pop takes the queue below full
// reset restores the ARGB mask layout and bitfields mode off, empties the pipeline

module bitfield_pixel_premultiply_unit import bpp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes, only while idle
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PIX_W-1:0]     cfg_wdata_i,
  // source pixel words
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PIX_W-1:0]     source_pixel_i,
  // premultiplied ARGB words
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CH_W-1:0]      alpha_out_o,
  output logic      [CH_W-1:0]      red_out_o,
  output logic      [CH_W-1:0]      green_out_o,
  output logic      [CH_W-1:0]      blue_out_o
);

  logic  push;
  argb_t push_data;
  logic  full;
  word_t head;
  logic  pop;
  argb_t out_data;

  // front: mask decode and channel extraction, same cycle as accept
  bpp_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .source_pixel_i,
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue, lets the front keep accepting while the back stalls
  bpp_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .head_o      (head),
    .pop_i       (pop)
  );

  // back: per-colour premultiply under gamma two, alpha delayed alongside
  bpp_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o  (out_data)
  );

  assign alpha_out_o = out_data.a;
  assign red_out_o   = out_data.r;
  assign green_out_o = out_data.g;
  assign blue_out_o  = out_data.b;

endmodule

`default_nettype wire
